[rtl/key_sensor_relay_controller_macros.svh]
// assertion helpers shared by the rtl files
`ifndef KEY_SENSOR_RELAY_CONTROLLER_MACROS_SVH
`define KEY_SENSOR_RELAY_CONTROLLER_MACROS_SVH

`ifndef SYNTHESIS

// checked at every edge outside reset
`define KSRC_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked at every edge, reset included
`define KSRC_ASSERT_ALWAYS(name, clk, prop, msg) \
   name: assert property (@(posedge clk) prop) else $error(msg);

`else

`define KSRC_ASSERT(name, clk, rst, prop, msg)
`define KSRC_ASSERT_ALWAYS(name, clk, prop, msg)

`endif

`endif

[rtl/ksrc_pkg.sv]
package ksrc_pkg;

   localparam int TIMER_BITS_DEFAULT = 16;
   localparam int LIGHT_BITS         = 12;
   localparam int TEMP_BITS          = 12;
   localparam int TICK_CFG_BITS      = 16;
   localparam int CSR_DATA_BITS      = 16;
   localparam int CSR_INDEX_BITS     = 3;

   typedef enum logic [1:0] {
      CMD_TICK      = 2'd0,
      CMD_SET_MODE  = 2'd1,
      CMD_SET_RELAY = 2'd2
   } ksrc_cmd_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_LIGHT_ON_LEVEL  = 3'd0,
      CSR_LIGHT_BAND      = 3'd1,
      CSR_FAN_ON_TEMP     = 3'd2,
      CSR_TEMP_BAND       = 3'd3,
      CSR_DEBOUNCE        = 3'd4,
      CSR_LONG_PRESS      = 3'd5,
      CSR_SENSOR_PERIOD   = 3'd6,
      CSR_HEARTBEAT       = 3'd7
   } ksrc_csr_index_type;

   localparam logic [3:0] RELAY_LIGHT = 4'd3;
   localparam logic [3:0] RELAY_FAN   = 4'd4;

   // temperatures at or below this are treated as a broken sensor
   localparam logic signed [TEMP_BITS-1:0] TEMP_INVALID_LIMIT = -12'sd1000;

   localparam logic [LIGHT_BITS-1:0]        LIGHT_ON_LEVEL_RESET  = 12'd1000;
   localparam logic [LIGHT_BITS-1:0]        LIGHT_BAND_RESET      = 12'd250;
   localparam logic signed [TEMP_BITS-1:0]  FAN_ON_TEMP_RESET     = 12'sd300;
   localparam logic [9:0]                   TEMP_BAND_RESET       = 10'd10;
   localparam logic [TICK_CFG_BITS-1:0]     DEBOUNCE_RESET        = 16'd30;
   localparam logic [TICK_CFG_BITS-1:0]     LONG_PRESS_RESET      = 16'd2000;
   localparam logic [TICK_CFG_BITS-1:0]     SENSOR_PERIOD_RESET   = 16'd500;
   localparam logic [TICK_CFG_BITS-1:0]     HEARTBEAT_RESET       = 16'd5000;

   typedef struct packed {
      logic [1:0]                  command;
      logic                        master_key;
      logic                        mode_key;
      logic [LIGHT_BITS-1:0]       light_level;
      logic signed [TEMP_BITS-1:0] temperature;
      logic                        mode_request;
      logic [3:0]                  relay_number;
      logic                        relay_value;
   } ksrc_req_type;

   typedef struct packed {
      logic       light_relay;
      logic       fan_relay;
      logic       manual_mode;
      logic       enabled;
      logic [1:0] relay_code;
      logic       report_strobe;
   } ksrc_rsp_type;

   typedef struct packed {
      logic [LIGHT_BITS-1:0]       light_on_level;
      logic [LIGHT_BITS-1:0]       light_band;
      logic signed [TEMP_BITS-1:0] fan_on_temp;
      logic [9:0]                  temp_band;
      logic [TICK_CFG_BITS-1:0]    debounce_ticks;
      logic [TICK_CFG_BITS-1:0]    long_press_ticks;
      logic [TICK_CFG_BITS-1:0]    sensor_period_ticks;
      logic [TICK_CFG_BITS-1:0]    heartbeat_ticks;
   } ksrc_cfg_type;

endpackage

[rtl/ksrc_engine.sv]
`include "key_sensor_relay_controller_macros.svh"

module ksrc_engine #(
   parameter int TIMER_BITS = ksrc_pkg::TIMER_BITS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step,
   input  ksrc_pkg::ksrc_req_type item,
   input  ksrc_pkg::ksrc_cfg_type cfg,
   output ksrc_pkg::ksrc_rsp_type result
);

   localparam int CMP_W = (TIMER_BITS > ksrc_pkg::TICK_CFG_BITS) ?
                          TIMER_BITS : ksrc_pkg::TICK_CFG_BITS;

   logic                  enabled_ff, enabled_in;
   logic                  mode_ff, mode_in;
   logic [1:0]            code_ff, code_in;
   logic                  light_ff, light_in;
   logic                  fan_ff, fan_in;
   logic                  prev_raw_ff, prev_raw_in;
   logic                  key_stable_ff, key_stable_in;
   logic                  long_done_ff, long_done_in;
   logic [TIMER_BITS-1:0] steady_ff, steady_in;
   logic [TIMER_BITS-1:0] hold_ff, hold_in;
   logic [TIMER_BITS-1:0] check_ff, check_in;
   logic [TIMER_BITS-1:0] beat_ff, beat_in;
   logic [1:0]            seen_code_ff, seen_code_in;
   logic                  seen_mode_ff, seen_mode_in;
   logic [1:0]            seen_trig_ff, seen_trig_in;
   logic                  first_due_ff, first_due_in;
   logic                  strobe;

   logic signed [ksrc_pkg::TEMP_BITS-1:0] temp_v;
   logic signed [ksrc_pkg::TEMP_BITS-1:0] temp_thr_v;
   logic signed [ksrc_pkg::TEMP_BITS:0]   temp_low;
   logic [ksrc_pkg::LIGHT_BITS:0]         light_high;
   logic                                  light_lo_trig;
   logic                                  light_hi_trig;
   logic                                  temp_hi_trig;
   logic                                  temp_lo_trig;
   logic                                  temp_valid;
   logic [1:0]                            trig;
   logic                                  relay_l;
   logic                                  relay_f;

   function automatic logic [TIMER_BITS-1:0] sat_inc(input logic [TIMER_BITS-1:0] c);
      return (c == '1) ? c : TIMER_BITS'(c + 1'b1);
   endfunction

   // sensor compares are independent of the state
   assign temp_v        = item.temperature;
   assign temp_thr_v    = cfg.fan_on_temp;
   assign light_high    = {1'b0, cfg.light_on_level} + {1'b0, cfg.light_band};
   assign temp_low      = (ksrc_pkg::TEMP_BITS+1)'(temp_thr_v) -
                          $signed({3'b000, cfg.temp_band});
   assign light_lo_trig = item.light_level < cfg.light_on_level;
   assign light_hi_trig = {1'b0, item.light_level} > light_high;
   assign temp_hi_trig  = temp_v > temp_thr_v;
   assign temp_lo_trig  = (ksrc_pkg::TEMP_BITS+1)'(temp_v) < temp_low;
   assign temp_valid    = temp_v > ksrc_pkg::TEMP_INVALID_LIMIT;
   assign trig          = {temp_hi_trig, light_lo_trig};

   assign relay_l = (item.relay_number == ksrc_pkg::RELAY_LIGHT) ? item.relay_value : light_ff;
   assign relay_f = (item.relay_number == ksrc_pkg::RELAY_FAN) ? item.relay_value : fan_ff;

   always_comb begin
      enabled_in    = enabled_ff;
      mode_in       = mode_ff;
      code_in       = code_ff;
      light_in      = light_ff;
      fan_in        = fan_ff;
      prev_raw_in   = prev_raw_ff;
      key_stable_in = key_stable_ff;
      long_done_in  = long_done_ff;
      steady_in     = steady_ff;
      hold_in       = hold_ff;
      check_in      = check_ff;
      beat_in       = beat_ff;
      seen_code_in  = seen_code_ff;
      seen_mode_in  = seen_mode_ff;
      seen_trig_in  = seen_trig_ff;
      first_due_in  = first_due_ff;
      strobe        = 1'b0;

      case (ksrc_pkg::ksrc_cmd_type'(item.command))
         ksrc_pkg::CMD_TICK: begin
            steady_in = sat_inc(steady_ff);
            hold_in   = sat_inc(hold_ff);
            check_in  = sat_inc(check_ff);
            beat_in   = sat_inc(beat_ff);

            // master switch
            if (!item.master_key) begin
               if (enabled_ff) begin
                  light_in     = 1'b0;
                  fan_in       = 1'b0;
                  code_in      = 2'b00;
                  enabled_in   = 1'b0;
                  long_done_in = 1'b0;
               end
            end else if (!enabled_ff) begin
               enabled_in = 1'b1;
               mode_in    = 1'b0;
            end

            // key debounce, short and long press
            if (enabled_in) begin
               if (item.mode_key != prev_raw_ff) begin
                  steady_in = '0;
               end
               if (CMP_W'(steady_in) > CMP_W'(cfg.debounce_ticks) &&
                   item.mode_key != key_stable_ff) begin
                  key_stable_in = item.mode_key;
                  if (item.mode_key) begin
                     hold_in      = '0;
                     long_done_in = 1'b0;
                  end else if (!long_done_in && mode_in) begin
                     code_in  = code_in + 2'b01;
                     light_in = code_in[1];
                     fan_in   = code_in[0];
                  end
               end
               if (key_stable_in && !long_done_in &&
                   CMP_W'(hold_in) >= CMP_W'(cfg.long_press_ticks)) begin
                  long_done_in = 1'b1;
                  mode_in      = !mode_in;
                  code_in      = 2'b00;
                  light_in     = 1'b0;
                  fan_in       = 1'b0;
               end
               prev_raw_in = item.mode_key;
            end

            // automatic sensor check with hysteresis
            if (enabled_in && !mode_in &&
                CMP_W'(check_in) > CMP_W'(cfg.sensor_period_ticks)) begin
               check_in = '0;
               if (light_lo_trig) begin
                  light_in = 1'b1;
               end else if (light_hi_trig) begin
                  light_in = 1'b0;
               end
               if (temp_valid) begin
                  if (temp_hi_trig) begin
                     fan_in = 1'b1;
                  end else if (temp_lo_trig) begin
                     fan_in = 1'b0;
                  end
               end
            end

            // change report
            if (first_due_ff || code_in != seen_code_ff || mode_in != seen_mode_ff ||
                trig != seen_trig_ff) begin
               strobe       = 1'b1;
               first_due_in = 1'b0;
               seen_code_in = code_in;
               seen_mode_in = mode_in;
               seen_trig_in = trig;
            end

            // heartbeat
            if (CMP_W'(beat_in) > CMP_W'(cfg.heartbeat_ticks)) begin
               beat_in = '0;
               strobe  = 1'b1;
            end
         end
         ksrc_pkg::CMD_SET_MODE: begin
            if (enabled_ff) begin
               mode_in  = item.mode_request;
               code_in  = 2'b00;
               light_in = 1'b0;
               fan_in   = 1'b0;
            end
         end
         ksrc_pkg::CMD_SET_RELAY: begin
            if (enabled_ff) begin
               code_in  = {relay_l, relay_f};
               light_in = relay_l;
               fan_in   = relay_f;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enabled_ff    <= 1'b0;
         mode_ff       <= 1'b0;
         code_ff       <= 2'b00;
         light_ff      <= 1'b0;
         fan_ff        <= 1'b0;
         prev_raw_ff   <= 1'b0;
         key_stable_ff <= 1'b0;
         long_done_ff  <= 1'b0;
         steady_ff     <= '0;
         hold_ff       <= '0;
         check_ff      <= '0;
         beat_ff       <= '0;
         seen_code_ff  <= 2'b00;
         seen_mode_ff  <= 1'b0;
         seen_trig_ff  <= 2'b00;
         first_due_ff  <= 1'b1;
      end else if (step) begin
         enabled_ff    <= enabled_in;
         mode_ff       <= mode_in;
         code_ff       <= code_in;
         light_ff      <= light_in;
         fan_ff        <= fan_in;
         prev_raw_ff   <= prev_raw_in;
         key_stable_ff <= key_stable_in;
         long_done_ff  <= long_done_in;
         steady_ff     <= steady_in;
         hold_ff       <= hold_in;
         check_ff      <= check_in;
         beat_ff       <= beat_in;
         seen_code_ff  <= seen_code_in;
         seen_mode_ff  <= seen_mode_in;
         seen_trig_ff  <= seen_trig_in;
         first_due_ff  <= first_due_in;
      end
   end

   assign result.light_relay   = light_in;
   assign result.fan_relay     = fan_in;
   assign result.manual_mode   = mode_in;
   assign result.enabled       = enabled_in;
   assign result.relay_code    = code_in;
   assign result.report_strobe = strobe;

   `KSRC_ASSERT(a_off_is_quiet, clock, reset,
      !enabled_ff |-> (code_ff == 2'b00) && !light_ff && !fan_ff,
      "relays or code active while disabled")
   `KSRC_ASSERT(a_manual_follows_code, clock, reset,
      enabled_ff && mode_ff |-> {light_ff, fan_ff} == code_ff,
      "manual relays differ from relay code")
   `KSRC_ASSERT(a_commands_hold_time, clock, reset,
      step && item.command != ksrc_pkg::CMD_TICK |=>
         $stable(steady_ff) && $stable(beat_ff) && $stable(check_ff),
      "timers moved on a command beat")

endmodule

[rtl/key_sensor_relay_controller.sv]
// channel   | ports                                  | direction
// ----------+----------------------------------------+----------
// request   | req_valid, req_stall, req_payload      | in
// response  | rsp_valid, rsp_stall, rsp_payload      | out
// csr       | csr_we, csr_index, csr_wdata           | in
//
// one beat per cycle while rsp_stall is low; every request beat gives exactly one response beat
// a beat passes the input register, then the state update into the result register
// the whole tick update is one pass of compare and counter logic in ksrc_engine
// synchronous active-high reset clears control state, not payload, and loads the csr defaults
// a stalled response holds the input register, which then stalls the request side

`include "key_sensor_relay_controller_macros.svh"

module key_sensor_relay_controller #(
   parameter int TIMER_BITS = ksrc_pkg::TIMER_BITS_DEFAULT
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  ksrc_pkg::ksrc_req_type                 req_payload,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output ksrc_pkg::ksrc_rsp_type                 rsp_payload,
   input  logic                                   csr_we,
   input  logic [ksrc_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [ksrc_pkg::CSR_DATA_BITS-1:0]     csr_wdata
);

   // input register
   logic                   in_valid_ff, in_valid_in;
   ksrc_pkg::ksrc_req_type in_item_ff;

   // result register
   logic                   rsp_valid_ff, rsp_valid_in;
   ksrc_pkg::ksrc_rsp_type rsp_item_ff;

   ksrc_pkg::ksrc_cfg_type cfg_ff;
   ksrc_pkg::ksrc_rsp_type next_result;

   logic advance;
   logic req_take;
   logic step;

   // result register frees up when empty or when its beat leaves
   assign advance  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;
   assign step      = in_valid_ff && advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      rsp_valid_in = advance ? in_valid_ff : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_item_ff <= req_payload;
      end
      if (step) begin
         rsp_item_ff <= next_result;
      end
   end

   // csr file; the user must write it only while the block is idle, the block does not enforce it
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.light_on_level      <= ksrc_pkg::LIGHT_ON_LEVEL_RESET;
         cfg_ff.light_band          <= ksrc_pkg::LIGHT_BAND_RESET;
         cfg_ff.fan_on_temp         <= ksrc_pkg::FAN_ON_TEMP_RESET;
         cfg_ff.temp_band           <= ksrc_pkg::TEMP_BAND_RESET;
         cfg_ff.debounce_ticks      <= ksrc_pkg::DEBOUNCE_RESET;
         cfg_ff.long_press_ticks    <= ksrc_pkg::LONG_PRESS_RESET;
         cfg_ff.sensor_period_ticks <= ksrc_pkg::SENSOR_PERIOD_RESET;
         cfg_ff.heartbeat_ticks     <= ksrc_pkg::HEARTBEAT_RESET;
      end else if (csr_we) begin
         case (ksrc_pkg::ksrc_csr_index_type'(csr_index))
            ksrc_pkg::CSR_LIGHT_ON_LEVEL: begin
               cfg_ff.light_on_level <= csr_wdata[ksrc_pkg::LIGHT_BITS-1:0];
            end
            ksrc_pkg::CSR_LIGHT_BAND: begin
               cfg_ff.light_band <= csr_wdata[ksrc_pkg::LIGHT_BITS-1:0];
            end
            ksrc_pkg::CSR_FAN_ON_TEMP: begin
               cfg_ff.fan_on_temp <= $signed(csr_wdata[ksrc_pkg::TEMP_BITS-1:0]);
            end
            ksrc_pkg::CSR_TEMP_BAND: begin
               cfg_ff.temp_band <= csr_wdata[9:0];
            end
            ksrc_pkg::CSR_DEBOUNCE: begin
               cfg_ff.debounce_ticks <= csr_wdata;
            end
            ksrc_pkg::CSR_LONG_PRESS: begin
               cfg_ff.long_press_ticks <= csr_wdata;
            end
            ksrc_pkg::CSR_SENSOR_PERIOD: begin
               cfg_ff.sensor_period_ticks <= csr_wdata;
            end
            ksrc_pkg::CSR_HEARTBEAT: begin
               cfg_ff.heartbeat_ticks <= csr_wdata;
            end
            default: begin
            end
         endcase
      end
   end

   // state and the per-beat update
   ksrc_engine #(
      .TIMER_BITS(TIMER_BITS)
   ) u_engine (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .item   (in_item_ff),
      .cfg    (cfg_ff),
      .result (next_result)
   );

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_item_ff;

   `KSRC_ASSERT(a_taken_beat_held, clock, reset,
      req_valid && !req_stall |=> in_valid_ff,
      "accepted request beat lost")
   `KSRC_ASSERT(a_step_fills_result, clock, reset,
      step |=> rsp_valid_ff,
      "processed beat gave no response")
   `KSRC_ASSERT_ALWAYS(a_no_stall_when_empty, clock,
      !in_valid_ff |-> !req_stall,
      "request stalled with an empty input register")

endmodule
